// ----- rtl/core/slrwe_pkg.sv -----
`default_nettype none
package slrwe_pkg;

  localparam int SLIP_W = 17;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [1:0] MODE_DRIVE = 2'd0;
  localparam logic [1:0] MODE_WALK  = 2'd1;

  localparam logic [CFG_AW-1:0] CFG_WIN_LEN    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_TURN_HOLD  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_WALK_HOLD  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_WALK_SPEED = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PERIOD     = 3'd4;

  typedef struct packed {
    logic               pose_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [47:0]        stamp;
    logic [1:0]         mode;
    logic               cmd_new;
    logic signed [15:0] cmd_trans;
    logic signed [15:0] cmd_rot;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/core/slip_ratio_window_estimator.sv -----
// each request: decode, then a 23-step mean divide of the window sum for the default
// window depth; when a slip sample is made, first 3 squares, 32 root steps, 16 divide
// steps (skipped when the slip is zero) and a window update before the mean divide
// a new request is taken only after the last result is handed on; a 2-entry input queue and a 1-entry result stage
// synchronous active-low reset: registers to defaults, window empty, no result pending
`default_nettype none
module slip_ratio_window_estimator import slrwe_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_pose_new,
  input  logic               in_pose_ok,
  input  logic signed [31:0] in_pos_x_mm,
  input  logic signed [31:0] in_pos_y_mm,
  input  logic signed [31:0] in_pos_z_mm,
  input  logic [47:0]        in_stamp_ms,
  input  logic [1:0]         in_locomotion_mode,
  input  logic               in_command_new,
  input  logic signed [15:0] in_cmd_translation,
  input  logic signed [15:0] in_cmd_rotation,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [16:0]        out_slip_ratio,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata
);

  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic              res_valid;
  logic              res_ready;
  logic [SLIP_W-1:0] res_slip;
  logic              out_valid_r;
  logic [SLIP_W-1:0] out_slip_r;

  slrwe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .pose_new  (in_pose_new),
    .pose_ok   (in_pose_ok),
    .pos_x     (in_pos_x_mm),
    .pos_y     (in_pos_y_mm),
    .pos_z     (in_pos_z_mm),
    .stamp     (in_stamp_ms),
    .mode      (in_locomotion_mode),
    .cmd_new   (in_command_new),
    .cmd_trans (in_cmd_translation),
    .cmd_rot   (in_cmd_rotation),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  slrwe_core #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_slip  (res_slip)
  );

  assign res_ready      = !out_valid_r || out_pop;
  assign out_empty      = !out_valid_r;
  assign out_slip_ratio = out_slip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_slip_r <= res_slip;
  end

`ifndef ASSERT_OFF
  a_slip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_slip_r <= 17'h10000))
    else $error("slip mean above one");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> $stable(out_slip_r))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/slrwe_front.sv -----
`default_nettype none
module slrwe_front import slrwe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               pose_new,
  input  logic               pose_ok,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [47:0]        stamp,
  input  logic [1:0]         mode,
  input  logic               cmd_new,
  input  logic signed [15:0] cmd_trans,
  input  logic signed [15:0] cmd_rot,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t      slot_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  item_t      entry;
  logic       take;
  logic       give;

  always_comb begin
    entry.pose_valid = pose_new & pose_ok;
    entry.pos_x      = pos_x;
    entry.pos_y      = pos_y;
    entry.pos_z      = pos_z;
    entry.stamp      = stamp;
    entry.mode       = mode;
    entry.cmd_new    = cmd_new;
    entry.cmd_trans  = cmd_trans;
    entry.cmd_rot    = cmd_rot;
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rd_r];
  assign take    = push && !full;
  assign give    = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (take) wr_r <= ~wr_r;
      if (give) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(take) - 2'(give);
    end
  end

  always_ff @(posedge clk) begin
    if (take) slot_r[wr_r] <= entry;
  end

endmodule
`default_nettype wire

// ----- rtl/core/slrwe_core.sv -----
`default_nettype none
module slrwe_core import slrwe_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [SLIP_W-1:0] res_slip
);

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SLIP_W + $clog2(MAX_WINDOW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_MSET = 4'd9;
  localparam logic [3:0] S_MEAN = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]         state_r;
  logic [5:0]         cnt_r;
  item_t              item_r;

  logic [LW-1:0]      win_len_r;
  logic [7:0]         turn_hold_r;
  logic [7:0]         walk_hold_r;
  logic [15:0]        walk_speed_r;
  logic [15:0]        period_r;

  logic signed [31:0] prev_x_r;
  logic signed [31:0] prev_y_r;
  logic signed [31:0] prev_z_r;
  logic [47:0]        prev_stamp_r;
  logic               have_prev_r;
  logic               have_cmd_r;
  logic signed [15:0] held_trans_r;
  logic signed [15:0] held_rot_r;
  logic               turning_r;
  logic               walking_r;
  logic [7:0]         hold_r;

  logic [31:0]        ax_r;
  logic [31:0]        ay_r;
  logic [31:0]        az_r;
  logic               big_r;
  logic [17:0]        dt_r;
  logic [15:0]        speed_r;
  logic [63:0]        acc_r;
  logic [63:0]        root_r;
  logic [63:0]        bit_r;
  logic [33:0]        den_r;
  logic [41:0]        num_r;
  logic [33:0]        rem_r;
  logic [SLIP_W-1:0]  quo_r;

  logic [AW-1:0]      p_r;
  logic [AW-1:0]      wp_r;
  logic               filled_r;
  logic [SUMW-1:0]    sum_r;
  logic [LW-1:0]      mrem_r;
  logic [SUMW-1:0]    mdiv_r;
  logic [SLIP_W-1:0]  res_r;

  logic [SLIP_W-1:0]  win_mem [MAX_WINDOW];
  logic [SLIP_W-1:0]  rdata_r;

  logic signed [50:0] dt_s;
  logic [17:0]        per3;
  logic               dt_ok;
  logic [31:0]        ax;
  logic [31:0]        ay;
  logic [31:0]        az;
  logic               trans_nz;
  logic               rot_nz;
  logic               live;
  logic               go_drive;
  logic               go_walk;
  logic [15:0]        trans_abs;
  logic [7:0]         hold_dec;
  logic [30:0]        sq_op;
  logic [61:0]        sq_p;
  logic [63:0]        sq_t;
  logic [34:0]        dr2;
  logic [AW-1:0]      p;
  logic [LW-1:0]      pn;
  logic [SLIP_W-1:0]  old;
  logic [LW:0]        mr2;
  logic               mbit;
  logic [SUMW-1:0]    mdiv_nxt;
  logic [CFG_DW-1:0]  wl_val;

  function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [32:0] n;
    d = $signed({a[31], a}) - $signed({b[31], b});
    n = -d;
    return (d < 0) ? n[31:0] : d[31:0];
  endfunction

  assign dt_s  = $signed({3'b0, item_r.stamp}) - $signed({3'b0, prev_stamp_r});
  assign per3  = {2'b0, period_r} + {1'b0, period_r, 1'b0};
  assign dt_ok = ((dt_s <<< 1) > $signed({35'b0, period_r})) &&
                 (dt_s < $signed({33'b0, per3}));
  assign ax    = absdiff(item_r.pos_x, prev_x_r);
  assign ay    = absdiff(item_r.pos_y, prev_y_r);
  assign az    = absdiff(item_r.pos_z, prev_z_r);

  assign trans_nz  = (held_trans_r != 16'sd0);
  assign rot_nz    = (held_rot_r != 16'sd0);
  assign live      = item_r.pose_valid && have_prev_r && have_cmd_r && dt_ok;
  assign go_drive  = (item_r.mode == MODE_DRIVE) && trans_nz && !turning_r && !walking_r;
  assign go_walk   = (item_r.mode == MODE_WALK) && trans_nz;
  assign trans_abs = held_trans_r[15] ? 16'(-held_trans_r) : held_trans_r;
  assign hold_dec  = (hold_r != 8'd0) ? hold_r - 8'd1 : 8'd0;

  assign sq_op = (cnt_r == 6'd0) ? ax_r[30:0] : (cnt_r == 6'd1) ? ay_r[30:0] : az_r[30:0];
  assign sq_p  = sq_op * sq_op;
  assign sq_t  = root_r + bit_r;
  assign dr2   = {rem_r, 1'b0};

  assign p    = (LW'(wp_r) >= win_len_r) ? '0 : wp_r;
  assign pn   = LW'(p_r) + LW'(1);
  assign old  = (filled_r || (p_r < wp_r)) ? rdata_r : '0;

  assign mr2      = {mrem_r, mdiv_r[SUMW-1]};
  assign mbit     = (mr2 >= {1'b0, win_len_r});
  assign mdiv_nxt = {mdiv_r[SUMW-2:0], mbit};

  assign wl_val = (cfg_wdata == '0) ? CFG_DW'(1) :
                  (cfg_wdata > CFG_DW'(MAX_WINDOW)) ? CFG_DW'(MAX_WINDOW) : cfg_wdata;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign res_valid = (state_r == S_OUT);
  assign res_slip  = res_r;

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) win_mem[p_r] <= quo_r;
    rdata_r <= win_mem[p];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      win_len_r    <= LW'(10);
      turn_hold_r  <= 8'd10;
      walk_hold_r  <= 8'd10;
      walk_speed_r <= 16'd10;
      period_r     <= 16'd100;
      have_prev_r  <= 1'b0;
      have_cmd_r   <= 1'b0;
      held_trans_r <= '0;
      held_rot_r   <= '0;
      turning_r    <= 1'b0;
      walking_r    <= 1'b0;
      hold_r       <= '0;
      wp_r         <= '0;
      filled_r     <= 1'b0;
      sum_r        <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          state_r <= S_MSET;
          if (item_r.pose_valid) begin
            if (live) begin
              if (item_r.mode == MODE_DRIVE) begin
                if (trans_nz) begin
                  if (turning_r || walking_r) begin
                    hold_r <= hold_dec;
                    if (hold_dec == 8'd0) begin
                      turning_r <= 1'b0;
                      walking_r <= 1'b0;
                    end
                  end
                end else if (rot_nz) begin
                  turning_r <= 1'b1;
                  hold_r    <= turn_hold_r;
                end
              end else if (item_r.mode == MODE_WALK) begin
                if (!walking_r) begin
                  sum_r     <= '0;
                  wp_r      <= '0;
                  filled_r  <= 1'b0;
                  walking_r <= 1'b1;
                  hold_r    <= walk_hold_r;
                end
              end
              if (go_drive || go_walk) state_r <= S_SQ;
            end
            ax_r         <= ax;
            ay_r         <= ay;
            az_r         <= az;
            big_r        <= ax[31] | ay[31] | az[31];
            dt_r         <= dt_s[17:0];
            speed_r      <= go_walk ? walk_speed_r : trans_abs;
            acc_r        <= '0;
            cnt_r        <= '0;
            prev_x_r     <= item_r.pos_x;
            prev_y_r     <= item_r.pos_y;
            prev_z_r     <= item_r.pos_z;
            prev_stamp_r <= item_r.stamp;
            have_prev_r  <= 1'b1;
            if (item_r.cmd_new) begin
              held_trans_r <= item_r.cmd_trans;
              held_rot_r   <= item_r.cmd_rot;
              have_cmd_r   <= 1'b1;
            end
          end
        end
        S_SQ: begin
          acc_r <= acc_r + {2'b0, sq_p};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd2) begin
            cnt_r   <= '0;
            root_r  <= '0;
            bit_r   <= 64'h4000_0000_0000_0000;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (acc_r >= sq_t) begin
            acc_r  <= acc_r - sq_t;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) state_r <= S_MUL;
        end
        S_MUL: begin
          den_r   <= speed_r * dt_r;
          num_r   <= 10'd1000 * root_r[31:0];
          state_r <= S_CMP;
        end
        S_CMP: begin
          cnt_r <= '0;
          if (big_r || (num_r >= {8'b0, den_r})) begin
            quo_r   <= '0;
            state_r <= S_RD;
          end else begin
            if (num_r == '0) begin
              quo_r <= SLIP_W'(1);
              rem_r <= '0;
            end else begin
              quo_r <= '0;
              rem_r <= den_r - num_r[33:0];
            end
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (dr2 >= {1'b0, den_r}) begin
            rem_r <= 34'(dr2 - {1'b0, den_r});
            quo_r <= {quo_r[SLIP_W-2:0], 1'b1};
          end else begin
            rem_r <= dr2[33:0];
            quo_r <= {quo_r[SLIP_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd15) state_r <= S_RD;
        end
        S_RD: begin
          p_r     <= p;
          state_r <= S_UPD;
        end
        S_UPD: begin
          sum_r <= sum_r - SUMW'(old) + SUMW'(quo_r);
          if (pn >= win_len_r) begin
            wp_r     <= '0;
            filled_r <= 1'b1;
          end else begin
            wp_r <= pn[AW-1:0];
          end
          state_r <= S_MSET;
        end
        S_MSET: begin
          mdiv_r  <= sum_r;
          mrem_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_MEAN;
        end
        S_MEAN: begin
          mrem_r <= mbit ? LW'(mr2 - {1'b0, win_len_r}) : mr2[LW-1:0];
          mdiv_r <= mdiv_nxt;
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'(SUMW - 1)) begin
            res_r   <= mdiv_nxt[SLIP_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_addr)
          CFG_WIN_LEN: begin
            win_len_r <= wl_val[LW-1:0];
            sum_r     <= '0;
            wp_r      <= '0;
            filled_r  <= 1'b0;
          end
          CFG_TURN_HOLD:  turn_hold_r  <= cfg_wdata[7:0];
          CFG_WALK_HOLD:  walk_hold_r  <= cfg_wdata[7:0];
          CFG_WALK_SPEED: walk_speed_r <= cfg_wdata;
          CFG_PERIOD:     period_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- dv/tb_slip_ratio_window_estimator.sv -----
module tb_slip_ratio_window_estimator;
  import slrwe_pkg::*;

  localparam logic [1:0] MODE_OTHER = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int WIN_MAX = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic               pose_new;
    logic               pose_ok;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [47:0]        stamp;
    logic [1:0]         mode;
    logic               cmd_new;
    logic signed [15:0] trans;
    logic signed [15:0] rot;
  } pose_req_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_full;
  logic in_pose_new = 0;
  logic in_pose_ok = 0;
  logic signed [31:0] in_pos_x_mm = 0;
  logic signed [31:0] in_pos_y_mm = 0;
  logic signed [31:0] in_pos_z_mm = 0;
  logic [47:0] in_stamp_ms = 0;
  logic [1:0] in_locomotion_mode = 0;
  logic in_command_new = 0;
  logic signed [15:0] in_cmd_translation = 0;
  logic signed [15:0] in_cmd_rotation = 0;
  logic out_empty;
  logic out_pop = 0;
  logic [16:0] out_slip_ratio;
  logic cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = CFG_WIN_LEN;
  logic [CFG_DW-1:0] cfg_wdata = 0;

  slip_ratio_window_estimator uut (.*);

  always #1 clk = ~clk;

  // predictor state
  int win_len, turn_hold, walk_hold, walk_speed, period;
  longint prev_x, prev_y, prev_z, prev_stamp;
  bit have_prev, have_cmd, turning, walking;
  longint held_trans, held_rot;
  int hold_cnt;
  int slip_win[WIN_MAX];
  int win_sum, wr_pos;

  logic [16:0] expected_slip[$];
  int fails = 0;
  int hold_off = 0;
  bit no_idle = 0;
  int stall_cycles = 0;

  // stimulus generator state
  longint gen_stamp;
  int gen_x, gen_y, gen_z;

  function automatic void clear_window();
    foreach (slip_win[i]) slip_win[i] = 0;
    win_sum = 0;
    wr_pos = 0;
  endfunction

  function automatic void model_reset();
    win_len = 10; turn_hold = 10; walk_hold = 10; walk_speed = 10; period = 100;
    prev_x = 0; prev_y = 0; prev_z = 0; prev_stamp = 0;
    have_prev = 0; have_cmd = 0; held_trans = 0; held_rot = 0;
    turning = 0; walking = 0; hold_cnt = 0;
    clear_window();
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs_step(longint a, longint b);
    return (a >= b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic int slip_of(longint unsigned ax, longint unsigned ay,
                                 longint unsigned az, longint unsigned spd,
                                 longint unsigned dt);
    longint unsigned den, num, lim;
    lim = 64'd1 << 31;
    den = spd * dt;
    if (ax >= lim || ay >= lim || az >= lim) return 0;
    num = 1000 * root_floor(ax * ax + ay * ay + az * az);
    if (num >= den) return 0;
    return int'(((den - num) << 16) / den);
  endfunction

  function automatic void window_add(int s);
    int p;
    p = wr_pos;
    if (p >= win_len) p = 0;
    win_sum = win_sum - slip_win[p] + s;
    slip_win[p] = s;
    p++;
    wr_pos = (p >= win_len) ? 0 : p;
  endfunction

  function automatic logic [16:0] predict_slip(pose_req_t r);
    longint dt, x, y, z;
    longint unsigned ax, ay, az, spd;
    if (r.pose_new && r.pose_ok) begin
      x = r.x; y = r.y; z = r.z;
      if (have_prev && have_cmd) begin
        dt = longint'({16'd0, r.stamp}) - prev_stamp;
        if (2 * dt > period && dt < 3 * longint'(period)) begin
          ax = abs_step(x, prev_x);
          ay = abs_step(y, prev_y);
          az = abs_step(z, prev_z);
          if (r.mode == MODE_DRIVE) begin
            if (held_trans != 0) begin
              if (turning || walking) begin
                if (hold_cnt > 0) hold_cnt--;
                if (hold_cnt == 0) begin
                  turning = 0;
                  walking = 0;
                end
              end else begin
                spd = (held_trans < 0) ? -held_trans : held_trans;
                window_add(slip_of(ax, ay, az, spd, dt));
              end
            end else if (held_rot != 0) begin
              turning = 1;
              hold_cnt = turn_hold;
            end
          end else if (r.mode == MODE_WALK) begin
            if (!walking) begin
              clear_window();
              walking = 1;
              hold_cnt = walk_hold;
            end
            if (held_trans != 0) window_add(slip_of(ax, ay, az, walk_speed, dt));
          end
        end
      end
      prev_x = x; prev_y = y; prev_z = z;
      prev_stamp = longint'({16'd0, r.stamp});
      have_prev = 1;
      if (r.cmd_new) begin
        held_trans = r.trans;
        held_rot = r.rot;
        have_cmd = 1;
      end
    end
    return 17'(win_sum / win_len);
  endfunction

  function automatic void model_config(logic [CFG_AW-1:0] idx, int v);
    case (idx)
      CFG_WIN_LEN: begin
        win_len = (v < 1) ? 1 : (v > WIN_MAX) ? WIN_MAX : v;
        clear_window();
      end
      CFG_TURN_HOLD:  turn_hold = v & 8'hFF;
      CFG_WALK_HOLD:  walk_hold = v & 8'hFF;
      CFG_WALK_SPEED: walk_speed = v & 16'hFFFF;
      CFG_PERIOD:     period = v & 16'hFFFF;
      default: ;
    endcase
  endfunction

  function automatic pose_req_t mk(logic pn, logic ok, int x, int y, int z, longint t,
                                   logic [1:0] m, logic cn, int tr, int rt);
    pose_req_t r;
    r.pose_new = pn; r.pose_ok = ok; r.x = x; r.y = y; r.z = z;
    r.stamp = t[47:0]; r.mode = m; r.cmd_new = cn; r.trans = tr[15:0]; r.rot = rt[15:0];
    return r;
  endfunction

  // checker and receiver
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_slip.size() == 0) begin
        $error("slip_ratio: unexpected result %0d", out_slip_ratio);
        fails++;
      end else begin
        logic [16:0] e;
        e = expected_slip.pop_front();
        if (out_slip_ratio !== e) begin
          $error("slip_ratio: expected %0d, actual %0d", e, out_slip_ratio);
          fails++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off--;
      out_pop <= 0;
    end else begin
      out_pop <= no_idle || ($urandom_range(99) >= 23);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(pose_req_t r);
    int gap;
    gap = (!no_idle && $urandom_range(99) < 23) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_push <= 0;
      repeat (gap) @(posedge clk);
    end
    in_pose_new <= r.pose_new; in_pose_ok <= r.pose_ok;
    in_pos_x_mm <= r.x; in_pos_y_mm <= r.y; in_pos_z_mm <= r.z;
    in_stamp_ms <= r.stamp; in_locomotion_mode <= r.mode;
    in_command_new <= r.cmd_new; in_cmd_translation <= r.trans; in_cmd_rotation <= r.rot;
    in_push <= 1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_slip.push_back(predict_slip(r));
  endtask

  task automatic wait_drained();
    in_push <= 0;
    while (expected_slip.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, int v);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v[CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 0;
    model_config(idx, v);
  endtask

  function automatic pose_req_t next_random();
    pose_req_t r;
    int a, k;
    k = $urandom_range(99);
    if (k < 8) begin
      r = mk($urandom_range(1), $urandom_range(1), $urandom, $urandom, $urandom,
             {$urandom, $urandom}, $urandom_range(3), $urandom_range(1),
             $urandom, $urandom);
      return r;
    end
    if ($urandom_range(19) == 0) gen_stamp += $urandom_range(0, 400);
    else if (period == 0) gen_stamp += $urandom_range(0, 50);
    else gen_stamp += (longint'(period) * $urandom_range(3, 32)) / 10;
    a = $urandom_range(0, 4000);
    gen_x += int'($urandom_range(0, 2 * a)) - a;
    gen_y += int'($urandom_range(0, 2 * a)) - a;
    gen_z += int'($urandom_range(0, a / 4 + 1)) - a / 8;
    if ($urandom_range(49) == 0) gen_x = $urandom;
    k = $urandom_range(9);
    r = mk(1, $urandom_range(19) != 0, gen_x, gen_y, gen_z, gen_stamp,
           (k < 7) ? MODE_DRIVE : (k < 9) ? MODE_WALK :
           ($urandom_range(1) ? MODE_OTHER : MODE_SPARE),
           $urandom_range(9) < 3, 0, 0);
    k = $urandom_range(19);
    r.trans = (k < 12) ? 16'(int'($urandom_range(0, 4000)) - 2000) :
              (k < 15) ? 16'd0 : 16'($urandom);
    r.rot = ($urandom_range(9) < 6) ? 16'd0 : 16'($urandom);
    return r;
  endfunction

  task automatic test_directed();
    send_request(mk(0, 1, 5, 5, 5, 1000, MODE_DRIVE, 1, 1000, 0));
    send_request(mk(1, 0, -1, -1, -1, 48'hFFFF_FFFF_FFFF, MODE_SPARE, 1, -1, -1));
    send_request(mk(1, 1, 0, 0, 0, 1000, MODE_DRIVE, 1, 1000, 0));
    send_request(mk(1, 1, 50, 0, 0, 1100, MODE_DRIVE, 0, 0, 0));
    send_request(mk(1, 1, 60, 10, -5, 1150, MODE_DRIVE, 0, 0, 0));
    send_request(mk(1, 1, 70, 20, -5, 1201, MODE_DRIVE, 0, 0, 0));
    send_request(mk(1, 1, 80, 20, 0, 1500, MODE_DRIVE, 0, 0, 0));
    send_request(mk(1, 1, 32'h8000_0000, 0, 0, 1800, MODE_DRIVE, 0, 0, 0));
    send_request(mk(1, 1, 32'h7FFF_FFFF, 0, 0, 1900, MODE_DRIVE, 0, 0, 0));
    send_request(mk(1, 1, 32'h7FFF_FFFF, 0, 0, 2000, MODE_DRIVE, 1, -32768, 0));
    send_request(mk(1, 1, 32'h7FFF_FF00, 0, 0, 2100, MODE_DRIVE, 1, 0, 5));
    send_request(mk(1, 1, 32'h7FFF_FF00, 0, 0, 2200, MODE_DRIVE, 1, 32767, 0));
    send_request(mk(1, 1, 32'h7FFF_FE00, 0, 0, 2300, MODE_DRIVE, 0, 0, 0));
    send_request(mk(1, 1, 32'h7FFF_FE00, 5, 5, 2400, MODE_WALK, 0, 0, 0));
    send_request(mk(1, 1, 32'h7FFF_FE00, 9, 5, 2500, MODE_WALK, 0, 0, 0));
    send_request(mk(1, 1, 0, -1, 0, 2600, MODE_OTHER, 0, 0, 0));
    send_request(mk(1, 1, 1, 1, 32'h7FFF_FFFF, 2700, MODE_SPARE, 1, 100, -32768));
    send_request(mk(1, 1, 2, 2, 2, 2600, MODE_DRIVE, 0, 0, 0));
    send_request(mk(1, 1, 2, 2, 2, 48'hFFFF_FFFF_FFFF, MODE_DRIVE, 0, 0, 0));
    send_request(mk(1, 1, 3, 3, 3, 48'hFFFF_FFFF_FFFF, MODE_DRIVE, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_WIN_LEN, 0);
    write_reg(CFG_TURN_HOLD, 0);
    write_reg(CFG_WALK_HOLD, 255);
    write_reg(CFG_WALK_SPEED, 0);
    write_reg(CFG_PERIOD, 0);
    repeat (15) send_request(next_random());
    wait_drained();
    write_reg(CFG_WIN_LEN, 127);
    write_reg(CFG_TURN_HOLD, 255);
    write_reg(CFG_WALK_HOLD, 0);
    write_reg(CFG_WALK_SPEED, 65535);
    write_reg(CFG_PERIOD, 65535);
    repeat (40) send_request(next_random());
    wait_drained();
    write_reg(CFG_PERIOD, 1);
    write_reg(CFG_WIN_LEN, 1);
    repeat (20) send_request(next_random());
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    repeat (12) send_request(next_random());
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_WIN_LEN, (ph == 2) ? WIN_MAX : $urandom_range(1, WIN_MAX));
      write_reg(CFG_TURN_HOLD, $urandom_range(0, 12));
      write_reg(CFG_WALK_HOLD, $urandom_range(0, 12));
      write_reg(CFG_WALK_SPEED, $urandom_range(1, 3) * 1000 + $urandom_range(0, 999));
      write_reg(CFG_PERIOD, (ph == 0) ? 100 : $urandom_range(1, 2000));
      no_idle = (ph == 3);
      repeat (260) send_request(next_random());
      wait_drained();
      no_idle = 0;
    end
  endtask

  initial begin
    model_reset();
    gen_stamp = 5000;
    gen_x = 0; gen_y = 0; gen_z = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
